>>> hdl/work_stealing_job_dispatcher_defines.svh
// ----------------------------------------------------------------------------
// work_stealing_job_dispatcher_defines
// assertion macros shared by the dispatcher rtl
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_JOB_DISPATCHER_DEFINES_SVH
`define WORK_STEALING_JOB_DISPATCHER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define WSJD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/wsjd_pkg.sv
// ----------------------------------------------------------------------------
// wsjd_pkg
// types and codes of the work-stealing job dispatcher
// ----------------------------------------------------------------------------
package wsjd_pkg;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_WORK   = 2'd1;
    localparam logic [1:0] OP_IO     = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_LOCAL   = 3'd2;
    localparam logic [2:0] ST_PRIO    = 3'd3;
    localparam logic [2:0] ST_STOLEN  = 3'd4;
    localparam logic [2:0] ST_IO      = 3'd5;
    localparam logic [2:0] ST_NONE    = 3'd6;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // stored handle width, fixed by the transaction fields
    localparam int HANDLE_WIDTH = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  worker;
        logic [15:0] job_handle;
        logic [1:0]  priority_req;
        logic        io_bound;
        logic        detached;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        job_valid;
        logic [15:0] job_out;
    } rsp_t;

endpackage

>>> hdl/work_stealing_job_dispatcher.sv
// ----------------------------------------------------------------------------
// work_stealing_job_dispatcher
// job dispatcher with per-worker deques, priority rings, an io ring and stealing
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with done high, and cannot be stalled.
// Submits, io pops and work requests served locally or from a ring pass after
// the accepting edge through the decode, wait and done states; done is
// registered in the done state, and busy stays high until the state returns
// to idle. A work request that reaches the steal stage with at least two
// active workers first takes the bit-serial lfsr remainder, then scans victim
// slots in turn, skipping itself, until it steals a job or n-1 visits run out
// (n active workers). The jobs sit in one synchronous memory holding all
// deques and rings; it has a single port and a registered read. The memory
// needs no clear.
`include "work_stealing_job_dispatcher_defines.svh"

module work_stealing_job_dispatcher
    import wsjd_pkg::*;
#(
    parameter int WORKERS      = 8,
    parameter int QUEUE_DEPTH  = 256,
    parameter int PRIORITIES   = 4
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    output logic       done,
    output rsp_t       rsp
);

    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int WW  = $clog2(WORKERS);
    localparam int PW  = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
    localparam int CW  = $clog2(WORKERS + 1);
    localparam int SLOTS = WORKERS + PRIORITIES + 1;
    localparam int SW  = $clog2(SLOTS);
    localparam int AW  = SW + QW;
    localparam int DEPTH = SLOTS * QUEUE_DEPTH;

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_MOD, S_SCAN, S_READ, S_WAIT, S_DONE} state_t;

    // job memory: deques, then priority rings, then io ring
    logic [HANDLE_WIDTH-1:0] mem [DEPTH];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;

    // pointers
    logic [QW:0]   dtop_reg [WORKERS];
    logic [QW:0]   dbot_reg [WORKERS];
    logic [QW-1:0] phead_reg [PRIORITIES];
    logic [QW-1:0] ptail_reg [PRIORITIES];
    logic [QW-1:0] iohead_reg, iotail_reg;
    logic [15:0]   lfsr_reg;
    logic [3:0]    active_reg;

    state_t        state_reg;
    req_t          req_reg;
    logic [CW-1:0] n_reg;
    logic [15:0]   mod_reg;
    logic [CW-1:0] rem_reg;
    logic [3:0]    bit_reg;
    logic [WW-1:0] vict_reg;
    logic [CW-1:0] left_reg;
    logic [SW-1:0] slot_reg;
    logic [QW-1:0] off_reg;
    logic          rd_reg;
    logic          wr_reg;
    logic [2:0]    st_reg;
    rsp_t          rsp_reg;
    logic          done_reg;

    // clamped active count and request decode
    logic [CW-1:0] n_c;
    logic [PW-1:0] pr_c;
    logic          is_wk;
    logic [WW-1:0] wk;
    logic [PW-1:0] hi_p;
    logic          any_p;

    always_comb
    begin
        if (active_reg == 4'd0)
            n_c = CW'(1);
        else if (32'(active_reg) > WORKERS)
            n_c = CW'(WORKERS);
        else
            n_c = CW'(active_reg);
    end

    always_comb
    begin
        if (32'(req_reg.priority_req) >= PRIORITIES)
            pr_c = PW'(PRIORITIES - 1);
        else
            pr_c = PW'(req_reg.priority_req);
        is_wk = 32'(req_reg.worker) < 32'(n_reg);
        wk    = WW'(req_reg.worker);
    end

    // highest non-empty priority ring
    always_comb
    begin
        hi_p  = '0;
        any_p = 1'b0;
        for (int p = 0; p < PRIORITIES; p++)
        begin
            if (phead_reg[p] != ptail_reg[p])
            begin
                hi_p  = PW'(p);
                any_p = 1'b1;
            end
        end
    end

    logic [QW:0] dcnt_wk, dcnt_v;
    assign dcnt_wk = dbot_reg[wk] - dtop_reg[wk];
    assign dcnt_v  = dbot_reg[vict_reg] - dtop_reg[vict_reg];

    assign mem_addr = {slot_reg, off_reg};
    assign mem_we   = wr_reg;

    // job memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= req_reg.job_handle[HANDLE_WIDTH-1:0];
        rd_data_reg <= mem[mem_addr];
    end

    logic [15:0] lfsr_n;
    assign lfsr_n = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    // one restoring remainder step of the lfsr value by n-1, msb first
    logic [CW-1:0] div_w;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_nx;
    logic [CW:0]   vsum;
    logic [WW-1:0] vict_c;
    assign div_w  = n_reg - 1'b1;
    assign rem_sh = {rem_reg, mod_reg[15]};
    assign rem_nx = (rem_sh >= {1'b0, div_w}) ? (rem_sh - {1'b0, div_w}) : rem_sh;

    // first victim: self + 1 + remainder, wrapped once at n
    assign vsum   = (CW+1)'(wk) + (CW+1)'(1) + rem_nx;
    assign vict_c = (vsum >= {1'b0, n_reg}) ? WW'(vsum - {1'b0, n_reg}) : WW'(vsum);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int i = 0; i < WORKERS; i++)
            begin
                dtop_reg[i] <= '0;
                dbot_reg[i] <= '0;
            end
            for (int i = 0; i < PRIORITIES; i++)
            begin
                phead_reg[i] <= '0;
                ptail_reg[i] <= '0;
            end
            iohead_reg <= '0;
            iotail_reg <= '0;
            lfsr_reg   <= LFSR_SEED;
            active_reg <= 4'd8;
            done_reg   <= 1'b0;
            wr_reg     <= 1'b0;
            rd_reg     <= 1'b0;
            req_reg    <= '0;
            n_reg      <= '0;
            mod_reg    <= '0;
            rem_reg    <= '0;
            bit_reg    <= '0;
            vict_reg   <= '0;
            left_reg   <= '0;
            slot_reg   <= '0;
            off_reg    <= '0;
            st_reg     <= ST_NONE;
            rsp_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            wr_reg   <= 1'b0;
            if (cfg_we)
                active_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        n_reg     <= n_c;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    rd_reg    <= 1'b0;
                    st_reg    <= ST_NONE;
                    state_reg <= S_WAIT;
                    case (req_reg.op)
                        OP_SUBMIT:
                        begin
                            st_reg <= ST_DROPPED;
                            if (req_reg.io_bound)
                            begin
                                if (iotail_reg + 1'b1 != iohead_reg)
                                begin
                                    slot_reg   <= SW'(WORKERS + PRIORITIES);
                                    off_reg    <= iotail_reg;
                                    wr_reg     <= 1'b1;
                                    iotail_reg <= iotail_reg + 1'b1;
                                    st_reg     <= ST_QUEUED;
                                end
                            end
                            else if (is_wk && !req_reg.detached)
                            begin
                                if (32'(dcnt_wk) < QUEUE_DEPTH)
                                begin
                                    slot_reg     <= SW'(wk);
                                    off_reg      <= dbot_reg[wk][QW-1:0];
                                    wr_reg       <= 1'b1;
                                    dbot_reg[wk] <= dbot_reg[wk] + 1'b1;
                                    st_reg       <= ST_QUEUED;
                                end
                            end
                            else if (ptail_reg[pr_c] + 1'b1 != phead_reg[pr_c])
                            begin
                                slot_reg        <= SW'(WORKERS + 32'(pr_c));
                                off_reg         <= ptail_reg[pr_c];
                                wr_reg          <= 1'b1;
                                ptail_reg[pr_c] <= ptail_reg[pr_c] + 1'b1;
                                st_reg          <= ST_QUEUED;
                            end
                        end
                        OP_IO:
                        begin
                            if (iohead_reg != iotail_reg)
                            begin
                                slot_reg   <= SW'(WORKERS + PRIORITIES);
                                off_reg    <= iohead_reg;
                                iohead_reg <= iohead_reg + 1'b1;
                                rd_reg     <= 1'b1;
                                st_reg     <= ST_IO;
                            end
                        end
                        OP_WORK:
                        begin
                            if (is_wk && dcnt_wk != '0)
                            begin
                                slot_reg     <= SW'(wk);
                                off_reg      <= QW'(dbot_reg[wk] - 1'b1);
                                dbot_reg[wk] <= dbot_reg[wk] - 1'b1;
                                rd_reg       <= 1'b1;
                                st_reg       <= ST_LOCAL;
                            end
                            else if (any_p)
                            begin
                                slot_reg        <= SW'(WORKERS + 32'(hi_p));
                                off_reg         <= phead_reg[hi_p];
                                phead_reg[hi_p] <= phead_reg[hi_p] + 1'b1;
                                rd_reg          <= 1'b1;
                                st_reg          <= ST_PRIO;
                            end
                            else if (is_wk && n_reg >= CW'(2))
                            begin
                                lfsr_reg  <= lfsr_n;
                                mod_reg   <= lfsr_n;
                                rem_reg   <= '0;
                                bit_reg   <= '0;
                                state_reg <= S_MOD;
                            end
                        end
                        default:
                        begin
                            st_reg <= ST_NONE;
                        end
                    endcase
                end
                S_MOD:
                begin
                    // lfsr remainder by n-1, one bit per cycle, msb first over all 16 bits
                    rem_reg <= rem_nx[CW-1:0];
                    mod_reg <= mod_reg << 1;
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 4'd15)
                    begin
                        vict_reg  <= vict_c;
                        left_reg  <= n_reg - 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (left_reg == '0)
                        state_reg <= S_WAIT;
                    else if (vict_reg != wk && dcnt_v != '0)
                    begin
                        slot_reg           <= SW'(vict_reg);
                        off_reg            <= dtop_reg[vict_reg][QW-1:0];
                        dtop_reg[vict_reg] <= dtop_reg[vict_reg] + 1'b1;
                        rd_reg             <= 1'b1;
                        st_reg             <= ST_STOLEN;
                        state_reg          <= S_WAIT;
                    end
                    else
                    begin
                        left_reg <= left_reg - 1'b1;
                        if (32'(vict_reg) + 1 >= 32'(n_reg))
                            vict_reg <= '0;
                        else
                            vict_reg <= vict_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    rsp_reg.status    <= st_reg;
                    rsp_reg.job_valid <= rd_reg;
                    rsp_reg.job_out   <= rd_reg ? 16'(rd_data_reg) : 16'd0;
                    done_reg          <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `WSJD_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accept must raise busy")
    `WSJD_ASSERT_IMP(a_valid_status, clk, rst_n, done && rsp.job_valid,
        rsp.status == ST_LOCAL || rsp.status == ST_PRIO
        || rsp.status == ST_STOLEN || rsp.status == ST_IO,
        "job without dispatch status")
    `WSJD_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result while busy")
    `WSJD_ASSERT_IMP(a_wr_no_rd, clk, rst_n, wr_reg, state_reg == S_WAIT, "write outside wait")

endmodule
